@@ design/i32cd_pkg.sv @@
// Package with class codes, match patterns and the decoded result type of the instruction decoder.
`timescale 1ns / 1ps

package i32cd_pkg;

	typedef enum logic [3:0] {
		CLS_MUL         = 4'd0,
		CLS_MUL_LONG    = 4'd1,
		CLS_SWAP        = 4'd2,
		CLS_BX          = 4'd3,
		CLS_HALF_XFER   = 4'd4,
		CLS_PSR_READ    = 4'd5,
		CLS_PSR_WRITE   = 4'd6,
		CLS_DATAPROC    = 4'd7,
		CLS_SINGLE_XFER = 4'd8,
		CLS_BRANCH      = 4'd9,
		CLS_BLOCK_XFER  = 4'd10,
		CLS_SWI         = 4'd11,
		CLS_UNDEF       = 4'd12
	} instr_class_t;

	localparam logic [31:0] MUL_MASK       = 32'h0fc0_00f0;
	localparam logic [31:0] MUL_MATCH      = 32'h0000_0090;
	localparam logic [31:0] MULL_MASK      = 32'h0f80_00f0;
	localparam logic [31:0] MULL_MATCH     = 32'h0080_0090;
	localparam logic [31:0] SWAP_MASK      = 32'h0fb0_00f0;
	localparam logic [31:0] SWAP_MATCH     = 32'h0100_0090;
	localparam logic [11:0] BX_KEY         = 12'b0001_0010_0001;
	localparam logic [31:0] HALF_MASK      = 32'h0e00_0090;
	localparam logic [31:0] HALF_MATCH     = 32'h0000_0090;
	localparam logic [31:0] PSR_RD_MASK    = 32'h0fb0_00f0;
	localparam logic [31:0] PSR_RD_MATCH   = 32'h0100_0000;
	localparam logic [31:0] SX_UNDEF_MASK  = 32'h0e00_0010;
	localparam logic [31:0] SX_UNDEF_MATCH = 32'h0600_0010;
	localparam logic [31:0] BRANCH_MASK    = 32'h0e00_0000;
	localparam logic [31:0] BRANCH_MATCH   = 32'h0a00_0000;
	localparam logic [31:0] SWI_MASK       = 32'h0f00_0000;

	localparam logic [1:0] GRP_DP   = 2'b00;
	localparam logic [1:0] GRP_SX   = 2'b01;
	localparam logic [1:0] GRP_BR   = 2'b10;
	localparam logic [1:0] GRP_COP  = 2'b11;

	typedef struct packed {
		instr_class_t cls;
		logic [3:0]   alu_opcode;
		logic         set_flags;
		logic         immediate_form;
		logic         bit_p_24;
		logic         bit_u_23;
		logic         bit_b_22;
		logic         bit_w_21;
		logic         load_store_l;
		logic [1:0]   shift_kind;
		logic         shift_by_imm;
		logic [1:0]   half_sh;
	} dec_result_t;

endpackage

@@ design/instr32_class_decoder.sv @@
// Top level of the 32-bit instruction class decoder: input register, decode, result register.
`timescale 1ns / 1ps

// Takes one instruction word per cycle on start (busy is always low) and presents the decoded
// class and control bits for one cycle with done high, after the input register, the decode
// logic and the result register; the receiver cannot stall, so each result must be taken in
// the cycle it appears. Only bits 27:20 and 7:4 of the word matter; control bits a class does
// not use read as zero.
module instr32_class_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] instruction_word,
	output logic        done,
	output logic [3:0]  instr_class,
	output logic [3:0]  alu_opcode,
	output logic        set_flags,
	output logic        immediate_form,
	output logic        bit_p_24,
	output logic        bit_u_23,
	output logic        bit_b_22,
	output logic        bit_w_21,
	output logic        load_store_l,
	output logic [1:0]  shift_kind,
	output logic        shift_by_imm,
	output logic [1:0]  half_sh
);

	logic                  valid_s1;
	logic [31:0]           word_s1;
	logic                  valid_s2;
	i32cd_pkg::dec_result_t res_s2;
	i32cd_pkg::dec_result_t dec;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			word_s1 <= instruction_word;
		end
		if (valid_s1) begin
			res_s2 <= dec;
		end
	end

	always_comb begin
		logic [31:0] w;
		logic [3:0]  op;
		logic        cmp;
		w   = word_s1;
		op  = w[24:21];
		cmp = (op[3:2] == 2'b10);
		dec = '0;
		dec.cls = i32cd_pkg::CLS_UNDEF;
		unique case (w[27:26])
			i32cd_pkg::GRP_DP: begin
				if ((w & i32cd_pkg::MUL_MASK) == i32cd_pkg::MUL_MATCH) begin
					dec.cls       = i32cd_pkg::CLS_MUL;
					dec.set_flags = w[20];
					dec.bit_w_21  = w[21];
				end else if ((w & i32cd_pkg::MULL_MASK) == i32cd_pkg::MULL_MATCH) begin
					dec.cls       = i32cd_pkg::CLS_MUL_LONG;
					dec.set_flags = w[20];
					dec.bit_w_21  = w[21];
					dec.bit_b_22  = w[22];
					dec.bit_u_23  = w[23];
				end else if ((w & i32cd_pkg::SWAP_MASK) == i32cd_pkg::SWAP_MATCH) begin
					dec.cls      = i32cd_pkg::CLS_SWAP;
					dec.bit_b_22 = w[22];
				end else if ({w[27:20], w[7:4]} == i32cd_pkg::BX_KEY) begin
					dec.cls = i32cd_pkg::CLS_BX;
				end else if ((w & i32cd_pkg::HALF_MASK) == i32cd_pkg::HALF_MATCH) begin
					dec.cls            = i32cd_pkg::CLS_HALF_XFER;
					dec.bit_p_24       = w[24];
					dec.bit_u_23       = w[23];
					dec.immediate_form = w[22];
					dec.bit_w_21       = w[21];
					dec.load_store_l   = w[20];
					dec.half_sh        = w[6:5];
				end else if (!w[20] && cmp) begin
					dec.bit_b_22 = w[22];
					if ((w & i32cd_pkg::PSR_RD_MASK) == i32cd_pkg::PSR_RD_MATCH) begin
						dec.cls = i32cd_pkg::CLS_PSR_READ;
					end else begin
						dec.cls            = i32cd_pkg::CLS_PSR_WRITE;
						dec.immediate_form = w[25];
					end
				end else begin
					dec.cls            = i32cd_pkg::CLS_DATAPROC;
					dec.alu_opcode     = op;
					dec.set_flags      = cmp | w[20];
					dec.immediate_form = w[25];
					dec.shift_kind     = w[6:5];
					dec.shift_by_imm   = ~w[4];
				end
			end
			i32cd_pkg::GRP_SX: begin
				if ((w & i32cd_pkg::SX_UNDEF_MASK) == i32cd_pkg::SX_UNDEF_MATCH) begin
					dec.cls = i32cd_pkg::CLS_UNDEF;
				end else begin
					dec.cls            = i32cd_pkg::CLS_SINGLE_XFER;
					dec.immediate_form = w[25];
					dec.bit_p_24       = w[24];
					dec.bit_u_23       = w[23];
					dec.bit_b_22       = w[22];
					dec.bit_w_21       = w[21];
					dec.load_store_l   = w[20];
					dec.shift_kind     = w[6:5];
				end
			end
			i32cd_pkg::GRP_BR: begin
				if ((w & i32cd_pkg::BRANCH_MASK) == i32cd_pkg::BRANCH_MATCH) begin
					dec.cls      = i32cd_pkg::CLS_BRANCH;
					dec.bit_p_24 = w[24];
				end else begin
					dec.cls          = i32cd_pkg::CLS_BLOCK_XFER;
					dec.bit_p_24     = w[24];
					dec.bit_u_23     = w[23];
					dec.bit_b_22     = w[22];
					dec.bit_w_21     = w[21];
					dec.load_store_l = w[20];
				end
			end
			i32cd_pkg::GRP_COP: begin
				if ((w & i32cd_pkg::SWI_MASK) == i32cd_pkg::SWI_MASK) begin
					dec.cls = i32cd_pkg::CLS_SWI;
				end else begin
					dec.cls = i32cd_pkg::CLS_UNDEF;
				end
			end
			default: begin
				dec.cls = i32cd_pkg::CLS_UNDEF;
			end
		endcase
	end

	assign done           = valid_s2;
	assign instr_class    = res_s2.cls;
	assign alu_opcode     = res_s2.alu_opcode;
	assign set_flags      = res_s2.set_flags;
	assign immediate_form = res_s2.immediate_form;
	assign bit_p_24       = res_s2.bit_p_24;
	assign bit_u_23       = res_s2.bit_u_23;
	assign bit_b_22       = res_s2.bit_b_22;
	assign bit_w_21       = res_s2.bit_w_21;
	assign load_store_l   = res_s2.load_store_l;
	assign shift_kind     = res_s2.shift_kind;
	assign shift_by_imm   = res_s2.shift_by_imm;
	assign half_sh        = res_s2.half_sh;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##2 done)
		else $error("accepted item did not produce a result two cycles later");

	a_class_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> instr_class <= i32cd_pkg::CLS_UNDEF)
		else $error("class code out of range");

	a_dp_only: assert property (@(posedge clk) disable iff (!arst_n)
		done && instr_class != i32cd_pkg::CLS_DATAPROC |-> alu_opcode == 4'd0 && !shift_by_imm)
		else $error("data processing fields set outside data processing");

	a_cmp_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done && instr_class == i32cd_pkg::CLS_DATAPROC && alu_opcode[3:2] == 2'b10 |-> set_flags)
		else $error("compare opcode without flag update");

	a_half_only: assert property (@(posedge clk) disable iff (!arst_n)
		done && instr_class != i32cd_pkg::CLS_HALF_XFER |-> half_sh == 2'd0)
		else $error("halfword selectors set outside halfword transfer");

endmodule

@@ tb/sv/instr32_class_decoder_test.sv @@
// Self-checking testbench for the instruction class decoder: directed and random words, scoreboard.
`timescale 1ns / 1ps

import i32cd_pkg::*;

class decode_scoreboard;
	dec_result_t expected_q[$];
	int unsigned mismatches;
	int unsigned words_in;
	int unsigned results_out;
	bit          class_hit[16];

	function dec_result_t predict_decode(logic [31:0] w);
		dec_result_t r;
		logic [3:0]  op;
		logic        cmp;
		r = '0;
		r.cls = CLS_UNDEF;
		op = w[24:21];
		cmp = (op[3:2] == 2'b10);
		case (w[27:26])
		GRP_DP: begin
			if ((w & MUL_MASK) == MUL_MATCH) begin
				r.cls = CLS_MUL;
				r.set_flags = w[20];
				r.bit_w_21 = w[21];
			end else if ((w & MULL_MASK) == MULL_MATCH) begin
				r.cls = CLS_MUL_LONG;
				r.set_flags = w[20];
				r.bit_w_21 = w[21];
				r.bit_b_22 = w[22];
				r.bit_u_23 = w[23];
			end else if ((w & SWAP_MASK) == SWAP_MATCH) begin
				r.cls = CLS_SWAP;
				r.bit_b_22 = w[22];
			end else if ({w[27:20], w[7:4]} == BX_KEY) begin
				r.cls = CLS_BX;
			end else if ((w & HALF_MASK) == HALF_MATCH) begin
				r.cls = CLS_HALF_XFER;
				r.bit_p_24 = w[24];
				r.bit_u_23 = w[23];
				r.immediate_form = w[22];
				r.bit_w_21 = w[21];
				r.load_store_l = w[20];
				r.half_sh = w[6:5];
			end else if (!w[20] && cmp) begin
				r.bit_b_22 = w[22];
				if ((w & PSR_RD_MASK) == PSR_RD_MATCH) begin
					r.cls = CLS_PSR_READ;
				end else begin
					r.cls = CLS_PSR_WRITE;
					r.immediate_form = w[25];
				end
			end else begin
				r.cls = CLS_DATAPROC;
				r.alu_opcode = op;
				r.set_flags = cmp ? 1'b1 : w[20];
				r.immediate_form = w[25];
				r.shift_kind = w[6:5];
				r.shift_by_imm = ~w[4];
			end
		end
		GRP_SX: begin
			if ((w & SX_UNDEF_MASK) == SX_UNDEF_MATCH) begin
				r.cls = CLS_UNDEF;
			end else begin
				r.cls = CLS_SINGLE_XFER;
				r.immediate_form = w[25];
				r.bit_p_24 = w[24];
				r.bit_u_23 = w[23];
				r.bit_b_22 = w[22];
				r.bit_w_21 = w[21];
				r.load_store_l = w[20];
				r.shift_kind = w[6:5];
			end
		end
		GRP_BR: begin
			if ((w & BRANCH_MASK) == BRANCH_MATCH) begin
				r.cls = CLS_BRANCH;
				r.bit_p_24 = w[24];
			end else begin
				r.cls = CLS_BLOCK_XFER;
				r.bit_p_24 = w[24];
				r.bit_u_23 = w[23];
				r.bit_b_22 = w[22];
				r.bit_w_21 = w[21];
				r.load_store_l = w[20];
			end
		end
		default: begin
			r.cls = ((w & SWI_MASK) == SWI_MASK) ? CLS_SWI : CLS_UNDEF;
		end
		endcase
		return r;
	endfunction

	function void note_word(logic [31:0] w);
		dec_result_t r;
		r = predict_decode(w);
		expected_q.push_back(r);
		class_hit[r.cls] = 1'b1;
		words_in++;
	endfunction

	function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			mismatches++;
		end
	endfunction

	function void check_result(dec_result_t got);
		dec_result_t e;
		results_out++;
		if (expected_q.size() == 0) begin
			$display("%0t: result with no item pending, actual %h", $time, got);
			mismatches++;
			return;
		end
		e = expected_q.pop_front();
		compare_field("instr_class", e.cls, got.cls);
		compare_field("alu_opcode", e.alu_opcode, got.alu_opcode);
		compare_field("set_flags", e.set_flags, got.set_flags);
		compare_field("immediate_form", e.immediate_form, got.immediate_form);
		compare_field("bit_p_24", e.bit_p_24, got.bit_p_24);
		compare_field("bit_u_23", e.bit_u_23, got.bit_u_23);
		compare_field("bit_b_22", e.bit_b_22, got.bit_b_22);
		compare_field("bit_w_21", e.bit_w_21, got.bit_w_21);
		compare_field("load_store_l", e.load_store_l, got.load_store_l);
		compare_field("shift_kind", e.shift_kind, got.shift_kind);
		compare_field("shift_by_imm", e.shift_by_imm, got.shift_by_imm);
		compare_field("half_sh", e.half_sh, got.half_sh);
	endfunction

	function int unsigned classes_covered();
		int unsigned n;
		n = 0;
		foreach (class_hit[k]) n += class_hit[k];
		return n;
	endfunction
endclass

module instr32_class_decoder_test;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [31:0] instruction_word = '0;
	logic        busy;
	logic        done;
	logic [3:0]  instr_class;
	logic [3:0]  alu_opcode;
	logic        set_flags;
	logic        immediate_form;
	logic        bit_p_24;
	logic        bit_u_23;
	logic        bit_b_22;
	logic        bit_w_21;
	logic        load_store_l;
	logic [1:0]  shift_kind;
	logic        shift_by_imm;
	logic [1:0]  half_sh;

	decode_scoreboard sb = new();

	localparam int unsigned RANDOM_WORDS = 1950;

	logic [31:0] directed_words[] = '{
		32'h0000_0000, 32'hffff_ffff, 32'h0000_0090, 32'h0030_0090,
		32'h00e0_0090, 32'h0080_0090, 32'h0100_0090, 32'h0140_0090,
		32'h012f_ff10, 32'h01d0_00b0, 32'h00f0_00f0, 32'h010f_0000,
		32'h014f_0000, 32'h0129_f000, 32'h0320_f000, 32'h0110_0000,
		32'h0080_0000, 32'h0000_0010, 32'h03f0_0060, 32'h0590_0000,
		32'h07ff_ffef, 32'h0600_0010, 32'h0a00_0000, 32'h0b00_0000,
		32'h08bd_0000, 32'h0f00_0000, 32'h0c00_0000, 32'h0e00_0010
	};

	instr32_class_decoder dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.instruction_word (instruction_word),
		.done             (done),
		.instr_class      (instr_class),
		.alu_opcode       (alu_opcode),
		.set_flags        (set_flags),
		.immediate_form   (immediate_form),
		.bit_p_24         (bit_p_24),
		.bit_u_23         (bit_u_23),
		.bit_b_22         (bit_b_22),
		.bit_w_21         (bit_w_21),
		.load_store_l     (load_store_l),
		.shift_kind       (shift_kind),
		.shift_by_imm     (shift_by_imm),
		.half_sh          (half_sh)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			sb.note_word(instruction_word);
		end
		if (arst_n && done) begin
			sb.check_result(dec_result_t'({instr_class, alu_opcode, set_flags, immediate_form,
				bit_p_24, bit_u_23, bit_b_22, bit_w_21, load_store_l, shift_kind,
				shift_by_imm, half_sh}));
		end
	end

	function automatic logic [31:0] random_word();
		logic [31:0] w;
		int unsigned kind;
		w = $urandom;
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			return w;
		end else if (kind < 18) begin
			w[27:22] = 6'b000000;
			w[7:4] = 4'b1001;
		end else if (kind < 26) begin
			w[27:23] = 5'b00001;
			w[7:4] = 4'b1001;
		end else if (kind < 31) begin
			w[27:23] = 5'b00010;
			w[21:20] = 2'b00;
			w[11:4] = 8'b0000_1001;
		end else if (kind < 35) begin
			w[27:20] = 8'h12;
			w[7:4] = 4'b0001;
		end else if (kind < 45) begin
			w[27:25] = 3'b000;
			w[7] = 1'b1;
			w[4] = 1'b1;
		end else if (kind < 50) begin
			w[27:20] = {3'b000, 2'b10, w[22], 2'b00};
			w[7:4] = 4'b0000;
		end else if (kind < 56) begin
			w[27:26] = 2'b00;
			w[24:23] = 2'b10;
			w[20] = 1'b0;
		end else if (kind < 70) begin
			w[27:26] = 2'b00;
		end else if (kind < 80) begin
			w[27:26] = 2'b01;
		end else if (kind < 86) begin
			w[27:25] = 3'b101;
		end else if (kind < 93) begin
			w[27:25] = 3'b100;
		end else begin
			w[27:26] = 2'b11;
		end
		return w;
	endfunction

	task automatic send_word(input logic [31:0] w);
		start <= 1'b1;
		instruction_word <= w;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic maybe_idle(input bit allow);
		if (allow && $urandom_range(0, 99) < 35) begin
			start <= 1'b0;
			instruction_word <= $urandom;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_words[k]) begin
			maybe_idle(k % 3 == 2);
			send_word(directed_words[k]);
		end
		drain_results();
		@(posedge clk);

		for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
			if (i == 1300) begin
				drain_results();
			end
			maybe_idle(i < 700 || i >= 1000);
			send_word(random_word());
		end
		drain_results();
		repeat (4) @(posedge clk);

		$display("Decoded %0d instruction words into %0d results, %0d of 13 classes reached.",
			sb.words_in, sb.results_out, sb.classes_covered());
		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timed out with %0d items pending.", sb.expected_q.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule
